// File: sv/gtc_pkg.sv
// Shared types, codes and helpers for the two-button gesture controller.
`timescale 1ns / 1ps
`default_nettype none
package gtc_pkg;

  localparam int MaxRes      = 4;
  localparam int QDepth      = 2;
  localparam int NumRegs     = 8;
  localparam int AddrW       = 5;
  localparam logic [6:0] NoneShown = 7'd127;
  localparam logic [31:0] ShortMinMs = 32'd50;

  typedef enum logic [3:0] {
    EV_NONE    = 4'd0,
    EV_TOGGLE  = 4'd1,
    EV_STEP    = 4'd2,
    EV_ROTATE  = 4'd3,
    EV_OFF     = 4'd4,
    EV_LIGHT   = 4'd5,
    EV_DEEP    = 4'd6,
    EV_REBOOT  = 4'd7,
    EV_FACTORY = 4'd8,
    EV_CANCEL  = 4'd9,
    EV_WAKE    = 4'd10,
    EV_COUNT   = 4'd11,
    EV_FCOUNT  = 4'd12
  } event_t;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_OFF    = 3'd1,
    ACT_LIGHT  = 3'd2,
    ACT_DEEP   = 3'd3,
    ACT_REBOOT = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_COMBO  = 2'd1,
    MODE_ARMED  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    REG_BURST   = 3'd0,
    REG_OFFHOLD = 3'd1,
    REG_RBHOLD  = 3'd2,
    REG_COMBO   = 3'd3,
    REG_FACTORY = 3'd4,
    REG_ARMS    = 3'd5,
    REG_ARML    = 3'd6,
    REG_IDLE    = 3'd7
  } reg_idx_t;

  // button flag bits
  localparam int FDown = 0;
  localparam int FLong = 1;
  localparam int FWake = 2;

  typedef struct packed {
    logic        key_down;
    logic        boot_down;
    logic [31:0] now_ms;
  } tick_t;

  typedef struct packed {
    logic [3:0] event_res;
    logic [7:0] click_count;
    logic [6:0] countdown_secs;
    logic [2:0] armed_action;
    logic       screen_is_on;
    logic       last_of_tick;
  } result_t;

  typedef struct packed {
    logic [15:0] burst_window_ms;
    logic [15:0] screen_off_hold_ms;
    logic [15:0] reboot_hold_ms;
    logic [15:0] dual_hold_ms;
    logic [15:0] factory_hold_ms;
    logic [15:0] countdown_short_ms;
    logic [15:0] countdown_long_ms;
    logic [7:0]  idle_sleep_min;
  } cfg_t;

  typedef struct packed {
    logic [2:0]                cnt;
    result_t [MaxRes-1:0]      res;
  } bundle_t;

  function automatic result_t mk_result(event_t ev, logic [7:0] cnt, logic [6:0] secs,
                                        action_t act, logic scr);
    result_t r;
    r.event_res      = ev;
    r.click_count    = cnt;
    r.countdown_secs = secs;
    r.armed_action   = act;
    r.screen_is_on   = scr;
    r.last_of_tick   = 1'b0;
    return r;
  endfunction

  // ceil(x/1000) for x below 65536, via reciprocal 67109 / 2^26
  function automatic logic [6:0] ceil_secs(logic [16:0] x);
    logic [17:0] xr;
    logic [34:0] p;
    xr = {1'b0, x} + 18'd999;
    p  = xr * 17'd67109;
    return p[32:26];
  endfunction

endpackage
`default_nettype wire

// File: sv/gtc_front.sv
// Front end: takes ticks, updates gesture state, builds one bundle of results per tick.
`timescale 1ns / 1ps
`default_nettype none
module gtc_front (
  input  wire                clk,
  input  wire                rst,
  input  gtc_pkg::cfg_t      cfg,
  input  wire                fire,
  input  gtc_pkg::tick_t     tick,
  output logic               push,
  output gtc_pkg::bundle_t   bundle
);
  import gtc_pkg::*;

  mode_t       mode, mode_next;
  action_t     pending_action, pending_action_next;
  logic [31:0] mode_start, mode_start_next;
  logic        released_once, released_once_next;
  logic [31:0] factory_start, factory_start_next;
  logic        factory_active, factory_active_next;
  logic [6:0]  shown_countdown, shown_countdown_next;
  logic [6:0]  shown_factory, shown_factory_next;
  logic [2:0]  key_flags, key_flags_next;
  logic [31:0] key_start, key_start_next;
  logic [2:0]  boot_flags, boot_flags_next;
  logic [31:0] boot_start, boot_start_next;
  logic [7:0]  click_tally, click_tally_next;
  logic [31:0] last_click_time, last_click_time_next;
  logic        screen_on, screen_on_next;
  logic [31:0] last_touch_time, last_touch_time_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_NORMAL;
      pending_action  <= ACT_NONE;
      mode_start      <= '0;
      released_once   <= 1'b0;
      factory_start   <= '0;
      factory_active  <= 1'b0;
      shown_countdown <= NoneShown;
      shown_factory   <= NoneShown;
      key_flags       <= '0;
      key_start       <= '0;
      boot_flags      <= '0;
      boot_start      <= '0;
      click_tally     <= '0;
      last_click_time <= '0;
      screen_on       <= 1'b1;
      last_touch_time <= '0;
    end else begin
      mode            <= mode_next;
      pending_action  <= pending_action_next;
      mode_start      <= mode_start_next;
      released_once   <= released_once_next;
      factory_start   <= factory_start_next;
      factory_active  <= factory_active_next;
      shown_countdown <= shown_countdown_next;
      shown_factory   <= shown_factory_next;
      key_flags       <= key_flags_next;
      key_start       <= key_start_next;
      boot_flags      <= boot_flags_next;
      boot_start      <= boot_start_next;
      click_tally     <= click_tally_next;
      last_click_time <= last_click_time_next;
      screen_on       <= screen_on_next;
      last_touch_time <= last_touch_time_next;
    end
  end

  always_comb begin
    logic        kp, bp, any, consumed, do_restart, is_reboot;
    logic [31:0] now, dur, elapsed, held;
    logic [2:0]  n;
    logic [6:0]  secs, fs;
    logic [23:0] idle_ms;

    kp = tick.key_down;
    bp = tick.boot_down;
    now = tick.now_ms;
    any = kp | bp;
    consumed = 1'b1;
    do_restart = 1'b0;
    is_reboot = (pending_action == ACT_REBOOT);
    n = '0;
    dur = '0;
    elapsed = '0;
    held = '0;
    secs = '0;
    fs = '0;
    idle_ms = cfg.idle_sleep_min * 16'd60000;
    bundle = '0;

    mode_next            = mode;
    pending_action_next  = pending_action;
    mode_start_next      = mode_start;
    released_once_next   = released_once;
    factory_start_next   = factory_start;
    factory_active_next  = factory_active;
    shown_countdown_next = shown_countdown;
    shown_factory_next   = shown_factory;
    key_flags_next       = key_flags;
    key_start_next       = key_start;
    boot_flags_next      = boot_flags;
    boot_start_next      = boot_start;
    click_tally_next     = click_tally;
    last_click_time_next = last_click_time;
    screen_on_next       = screen_on;
    last_touch_time_next = last_touch_time;

    if (fire) begin
      unique case (mode)
        MODE_NORMAL: begin
          if (kp && bp) begin
            mode_next = MODE_COMBO;
            mode_start_next = now;
            key_flags_next[FDown] = 1'b0;
            boot_flags_next[FDown] = 1'b0;
            click_tally_next = '0;
          end else begin
            consumed = 1'b0;
          end
        end
        MODE_COMBO: begin
          if (!(kp && bp)) begin
            mode_next = MODE_NORMAL;
            key_flags_next[FDown] = 1'b0;
            boot_flags_next[FDown] = 1'b0;
          end else if (now - mode_start >= {16'd0, cfg.dual_hold_ms}) begin
            // arm deep sleep, waiting for release
            mode_next = MODE_ARMED;
            pending_action_next = ACT_DEEP;
            mode_start_next = now;
            shown_countdown_next = NoneShown;
            shown_factory_next = NoneShown;
            factory_active_next = 1'b0;
            released_once_next = 1'b0;
            screen_on_next = 1'b1;
          end
        end
        default: begin
          if (!any) released_once_next = 1'b1;
          if (is_reboot) begin
            if (bp) begin
              if (!factory_active) begin
                factory_active_next = 1'b1;
                factory_start_next = now;
              end
            end else begin
              factory_active_next = 1'b0;
            end
          end
          held = now - factory_start_next;
          if (is_reboot && factory_active_next && held >= {16'd0, cfg.factory_hold_ms}) begin
            do_restart = 1'b1;
            bundle.res[0] = mk_result(EV_FACTORY, '0, '0, ACT_REBOOT, 1'b1);
            n = 3'd1;
          end else if (released_once_next && (is_reboot ? kp : any)) begin
            mode_next = MODE_NORMAL;
            pending_action_next = ACT_NONE;
            key_flags_next = {kp, 1'b1, kp};
            boot_flags_next = {bp, 1'b1, bp};
            key_start_next = now;
            boot_start_next = now;
            click_tally_next = '0;
            factory_active_next = 1'b0;
            last_touch_time_next = now;
            bundle.res[0] = mk_result(EV_CANCEL, '0, '0, pending_action, screen_on);
            n = 3'd1;
          end else begin
            dur = (pending_action == ACT_DEEP || is_reboot) ?
                  {16'd0, cfg.countdown_long_ms} : {16'd0, cfg.countdown_short_ms};
            elapsed = now - mode_start;
            if (elapsed >= dur) begin
              mode_next = MODE_NORMAL;
              pending_action_next = ACT_NONE;
              case (pending_action)
                ACT_OFF: begin
                  screen_on_next = 1'b0;
                  bundle.res[0] = mk_result(EV_OFF, '0, '0, ACT_OFF, 1'b0);
                  n = 3'd1;
                end
                ACT_LIGHT: begin
                  screen_on_next = 1'b0;
                  bundle.res[0] = mk_result(EV_LIGHT, '0, '0, ACT_LIGHT, 1'b0);
                  n = 3'd1;
                end
                ACT_DEEP: begin
                  do_restart = 1'b1;
                  bundle.res[0] = mk_result(EV_DEEP, '0, '0, ACT_DEEP, 1'b1);
                  n = 3'd1;
                end
                ACT_REBOOT: begin
                  do_restart = 1'b1;
                  bundle.res[0] = mk_result(EV_REBOOT, '0, '0, ACT_REBOOT, 1'b1);
                  n = 3'd1;
                end
                default: n = 3'd0;
              endcase
            end else begin
              secs = ceil_secs(dur[16:0] - elapsed[16:0]);
              fs = ceil_secs({1'b0, cfg.factory_hold_ms} - held[16:0]);
              if (is_reboot && factory_active_next) begin
                if (fs != shown_factory) begin
                  shown_factory_next = fs;
                  shown_countdown_next = NoneShown;
                  bundle.res[0] = mk_result(EV_FCOUNT, '0, fs, pending_action, screen_on);
                  n = 3'd1;
                end
              end else if (secs != shown_countdown) begin
                shown_countdown_next = secs;
                shown_factory_next = NoneShown;
                bundle.res[0] = mk_result(EV_COUNT, '0, secs, pending_action, screen_on);
                n = 3'd1;
              end
            end
          end
        end
      endcase

      if (!consumed) begin
        // KEY
        if (kp && !key_flags_next[FDown]) begin
          key_start_next = now;
          key_flags_next = {!screen_on_next, 1'b0, 1'b1};
          if (!screen_on_next) begin
            screen_on_next = 1'b1;
            bundle.res[n[1:0]] = mk_result(EV_WAKE, '0, '0, ACT_NONE, 1'b1);
            n = n + 3'd1;
          end
          last_touch_time_next = now;
        end else if (kp && !key_flags_next[FLong] && !key_flags_next[FWake] &&
                     now - key_start_next >= {16'd0, cfg.reboot_hold_ms}) begin
          key_flags_next[FLong] = 1'b1;
          click_tally_next = '0;
          mode_next = MODE_ARMED;
          pending_action_next = ACT_REBOOT;
          mode_start_next = now;
          shown_countdown_next = NoneShown;
          shown_factory_next = NoneShown;
          factory_active_next = 1'b0;
          released_once_next = 1'b0;
          screen_on_next = 1'b1;
        end else if (!kp && key_flags_next[FDown]) begin
          key_flags_next[FDown] = 1'b0;
          if (!key_flags_next[FLong] && !key_flags_next[FWake] &&
              now - key_start_next >= ShortMinMs) begin
            if (click_tally_next != 8'd255) click_tally_next = click_tally_next + 8'd1;
            last_click_time_next = now;
          end
        end
        // BOOT
        if (bp && !boot_flags_next[FDown]) begin
          boot_start_next = now;
          boot_flags_next = {!screen_on_next, 1'b0, 1'b1};
          if (!screen_on_next) begin
            screen_on_next = 1'b1;
            bundle.res[n[1:0]] = mk_result(EV_WAKE, '0, '0, ACT_NONE, 1'b1);
            n = n + 3'd1;
          end
          last_touch_time_next = now;
        end else if (bp && !boot_flags_next[FLong] && !boot_flags_next[FWake] &&
                     now - boot_start_next >= {16'd0, cfg.screen_off_hold_ms}) begin
          boot_flags_next[FLong] = 1'b1;
          mode_next = MODE_ARMED;
          pending_action_next = ACT_OFF;
          mode_start_next = now;
          shown_countdown_next = NoneShown;
          shown_factory_next = NoneShown;
          factory_active_next = 1'b0;
          released_once_next = 1'b0;
          screen_on_next = 1'b1;
        end else if (!bp && boot_flags_next[FDown]) begin
          boot_flags_next[FDown] = 1'b0;
          if (!boot_flags_next[FLong] && !boot_flags_next[FWake] &&
              now - boot_start_next >= ShortMinMs) begin
            bundle.res[n[1:0]] = mk_result(EV_ROTATE, '0, '0, ACT_NONE, screen_on_next);
            n = n + 3'd1;
          end
        end
        // close the burst
        if (click_tally_next != 8'd0 &&
            now - last_click_time_next > {16'd0, cfg.burst_window_ms}) begin
          if (click_tally_next == 8'd2)
            bundle.res[n[1:0]] = mk_result(EV_TOGGLE, '0, '0, ACT_NONE, screen_on_next);
          else
            bundle.res[n[1:0]] = mk_result(EV_STEP, click_tally_next, '0, ACT_NONE,
                                           screen_on_next);
          click_tally_next = '0;
          n = n + 3'd1;
        end
        // idle arming of light sleep
        if (!screen_on_next && cfg.idle_sleep_min != 8'd0 &&
            now - last_touch_time_next >= {8'd0, idle_ms}) begin
          mode_next = MODE_ARMED;
          pending_action_next = ACT_LIGHT;
          mode_start_next = now;
          shown_countdown_next = NoneShown;
          shown_factory_next = NoneShown;
          factory_active_next = 1'b0;
          released_once_next = 1'b1;
          screen_on_next = 1'b1;
        end
      end

      if (do_restart) begin
        mode_next            = MODE_NORMAL;
        pending_action_next  = ACT_NONE;
        mode_start_next      = '0;
        released_once_next   = 1'b0;
        factory_start_next   = '0;
        factory_active_next  = 1'b0;
        shown_countdown_next = NoneShown;
        shown_factory_next   = NoneShown;
        key_flags_next       = '0;
        key_start_next       = '0;
        boot_flags_next      = '0;
        boot_start_next      = '0;
        click_tally_next     = '0;
        last_click_time_next = '0;
        screen_on_next       = 1'b1;
        last_touch_time_next = now;
      end
    end

    bundle.cnt = n;
    push = fire && (n != 3'd0);
  end

endmodule
`default_nettype wire

// File: sv/gtc_queue.sv
// Short queue of result bundles between front and back.
`timescale 1ns / 1ps
`default_nettype none
module gtc_queue #(
  parameter int DEPTH = gtc_pkg::QDepth
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  input  gtc_pkg::bundle_t   wr_data,
  output logic               full,
  input  wire                pop,
  output logic               not_empty,
  output gtc_pkg::bundle_t   rd_data
);
  import gtc_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  bundle_t           mem [DEPTH];
  logic [PtrW-1:0]   wptr, rptr;
  logic [PtrW:0]     count;

  assign full      = (count == (PtrW+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_data   = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PtrW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == PtrW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      count <= count + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

// File: sv/gtc_back.sv
// Back end: issue the results of the head bundle one beat at a time.
`timescale 1ns / 1ps
`default_nettype none
module gtc_back (
  input  wire                clk,
  input  wire                rst,
  input  wire                head_valid,
  input  gtc_pkg::bundle_t   head,
  output logic               pop,
  output logic               result_valid,
  input  wire                result_ready,
  output gtc_pkg::result_t   result
);
  import gtc_pkg::*;

  logic [1:0] idx;
  logic       last;

  always_comb begin
    last   = ({1'b0, idx} == head.cnt - 3'd1);
    result = head.res[idx];
    result.last_of_tick = last;
    result_valid = head_valid;
    pop = head_valid && result_ready && last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (head_valid && result_ready) begin
      idx <= last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule
`default_nettype wire

// File: sv/two_button_gesture_controller.sv
// Top level of the two-button gesture controller: register port, front, queue, back.
// A tick's bundle is registered into the bundle queue when the tick is accepted; its first
// result is issued once that bundle reaches the queue head. Throughput: one tick a cycle
// while the queue is not full; each result takes one beat on the result channel.
// The front stalls only when the bundle queue is full.
// Reset (synchronous, rst high): gesture state and registers return to their defaults.
`timescale 1ns / 1ps
`default_nettype none
module two_button_gesture_controller #(
  parameter int QUEUE_DEPTH = gtc_pkg::QDepth
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          tick_valid,
  output logic                         tick_ready,
  input  gtc_pkg::tick_t               tick,
  output logic                         result_valid,
  input  wire                          result_ready,
  output gtc_pkg::result_t             result,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [gtc_pkg::AddrW-1:0]     paddr,
  input  wire [31:0]                   pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import gtc_pkg::*;

  cfg_t     cfg;
  logic     fire, push, full, head_valid, pop;
  bundle_t  wr_bundle, head;
  reg_idx_t ridx;

  // Register file: written on the access phase of an APB write.
  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[AddrW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.burst_window_ms    <= 16'd280;
      cfg.screen_off_hold_ms <= 16'd2000;
      cfg.reboot_hold_ms     <= 16'd10000;
      cfg.dual_hold_ms       <= 16'd5000;
      cfg.factory_hold_ms    <= 16'd2000;
      cfg.countdown_short_ms <= 16'd3000;
      cfg.countdown_long_ms  <= 16'd5000;
      cfg.idle_sleep_min     <= 8'd0;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_BURST:   cfg.burst_window_ms    <= pwdata[15:0];
        REG_OFFHOLD: cfg.screen_off_hold_ms <= pwdata[15:0];
        REG_RBHOLD:  cfg.reboot_hold_ms     <= pwdata[15:0];
        REG_COMBO:   cfg.dual_hold_ms       <= pwdata[15:0];
        REG_FACTORY: cfg.factory_hold_ms    <= pwdata[15:0];
        REG_ARMS:    cfg.countdown_short_ms <= pwdata[15:0];
        REG_ARML:    cfg.countdown_long_ms  <= pwdata[15:0];
        REG_IDLE:    cfg.idle_sleep_min     <= pwdata[7:0];
        default:     cfg.idle_sleep_min     <= cfg.idle_sleep_min;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_BURST:   prdata = {16'd0, cfg.burst_window_ms};
      REG_OFFHOLD: prdata = {16'd0, cfg.screen_off_hold_ms};
      REG_RBHOLD:  prdata = {16'd0, cfg.reboot_hold_ms};
      REG_COMBO:   prdata = {16'd0, cfg.dual_hold_ms};
      REG_FACTORY: prdata = {16'd0, cfg.factory_hold_ms};
      REG_ARMS:    prdata = {16'd0, cfg.countdown_short_ms};
      REG_ARML:    prdata = {16'd0, cfg.countdown_long_ms};
      REG_IDLE:    prdata = {24'd0, cfg.idle_sleep_min};
      default:     prdata = '0;
    endcase
  end

  // Take a tick whenever the queue has room for its bundle, even with results waiting.
  assign tick_ready = !full;
  assign fire       = tick_valid && tick_ready;

  gtc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (fire),
    .tick   (tick),
    .push   (push),
    .bundle (wr_bundle)
  );

  gtc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_data   (wr_bundle),
    .full      (full),
    .pop       (pop),
    .not_empty (head_valid),
    .rd_data   (head)
  );

  // Drain the head bundle, marking the final beat of each tick.
  gtc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the two-button gesture controller.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import gtc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic tick_valid = 1'b0;
  logic tick_ready;
  tick_t tick = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  two_button_gesture_controller uut (
    .clk(clk), .rst(rst),
    .tick_valid(tick_valid), .tick_ready(tick_ready), .tick(tick),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Gesture predictor: a behavioural copy of the controller state.
  // ---------------------------------------------------------------------------
  cfg_t      cfg;
  mode_t     g_mode;
  action_t   g_pend;
  logic      g_released, g_fact_on, g_screen;
  logic [6:0] g_shown_cd, g_shown_fc;
  logic [2:0] g_kflags, g_bflags;
  logic [7:0] g_tally;
  logic [31:0] g_mode_t0, g_fact_t0, g_key_t0, g_boot_t0, g_click_t, g_touch_t;

  result_t   expected_results[$];
  result_t   tick_out[$];
  int        failures = 0;
  int        idle_cycles = 0;
  logic [31:0] now_clock = 32'd0;
  logic      hold_off = 1'b0;

  task automatic clear_gestures();
    g_mode = MODE_NORMAL; g_pend = ACT_NONE; g_released = 0; g_fact_on = 0;
    g_shown_cd = NoneShown; g_shown_fc = NoneShown;
    g_kflags = '0; g_bflags = '0; g_tally = '0; g_screen = 1'b1;
    g_mode_t0 = '0; g_fact_t0 = '0; g_key_t0 = '0; g_boot_t0 = '0;
    g_click_t = '0; g_touch_t = '0;
  endtask

  task automatic post(event_t ev, logic [7:0] cnt, logic [6:0] secs, action_t act);
    result_t r;
    r.event_res = ev; r.click_count = cnt; r.countdown_secs = secs;
    r.armed_action = act; r.screen_is_on = g_screen; r.last_of_tick = 1'b0;
    tick_out.push_back(r);
  endtask

  task automatic arm_action(action_t act, logic wait_release, logic [31:0] now);
    g_mode = MODE_ARMED; g_pend = act; g_mode_t0 = now;
    g_shown_cd = NoneShown; g_shown_fc = NoneShown;
    g_fact_on = 0; g_released = !wait_release; g_screen = 1'b1;
  endtask

  task automatic restart_all(logic [31:0] now);
    clear_gestures();
    g_touch_t = now;
  endtask

  task automatic armed_step(logic kp, logic bp, logic [31:0] now);
    logic is_rb;
    action_t act;
    logic [31:0] dur, elapsed, secs, held, fs;
    is_rb = (g_pend == ACT_REBOOT);
    act = g_pend;
    if (!(kp || bp)) g_released = 1;
    if (is_rb) begin
      if (bp) begin
        if (!g_fact_on) begin
          g_fact_on = 1; g_fact_t0 = now;
        end
      end else begin
        g_fact_on = 0;
      end
      if (g_fact_on && (now - g_fact_t0) >= {16'd0, cfg.factory_hold_ms}) begin
        restart_all(now);
        post(EV_FACTORY, 0, 0, ACT_REBOOT);
        return;
      end
    end
    if (g_released && (is_rb ? kp : (kp || bp))) begin
      g_mode = MODE_NORMAL; g_pend = ACT_NONE;
      g_kflags = 3'b010 | (kp ? 3'b101 : 3'b000);
      g_bflags = 3'b010 | (bp ? 3'b101 : 3'b000);
      g_key_t0 = now; g_boot_t0 = now;
      g_tally = 0; g_fact_on = 0; g_touch_t = now;
      post(EV_CANCEL, 0, 0, act);
      return;
    end
    dur = (act == ACT_DEEP || act == ACT_REBOOT) ? {16'd0, cfg.countdown_long_ms}
                                                  : {16'd0, cfg.countdown_short_ms};
    elapsed = now - g_mode_t0;
    if (elapsed >= dur) begin
      g_mode = MODE_NORMAL; g_pend = ACT_NONE;
      case (act)
        ACT_OFF: begin
          g_screen = 0; post(EV_OFF, 0, 0, act);
        end
        ACT_LIGHT: begin
          g_screen = 0; post(EV_LIGHT, 0, 0, act);
        end
        ACT_DEEP: begin
          restart_all(now); post(EV_DEEP, 0, 0, act);
        end
        ACT_REBOOT: begin
          restart_all(now); post(EV_REBOOT, 0, 0, act);
        end
        default: ;
      endcase
      return;
    end
    secs = (dur - elapsed + 32'd999) / 32'd1000;
    if (is_rb && g_fact_on) begin
      held = now - g_fact_t0;
      fs = ({16'd0, cfg.factory_hold_ms} - held + 32'd999) / 32'd1000;
      if (fs[6:0] != g_shown_fc || fs > 32'd127) begin
        g_shown_fc = fs[6:0]; g_shown_cd = NoneShown;
        post(EV_FCOUNT, 0, fs[6:0], act);
      end
    end else if (secs[6:0] != g_shown_cd || secs > 32'd127) begin
      g_shown_cd = secs[6:0]; g_shown_fc = NoneShown;
      post(EV_COUNT, 0, secs[6:0], act);
    end
  endtask

  // Work out the results of one tick and append them to the expectation queue.
  task automatic predict_gestures(tick_t t);
    logic kp, bp, free;
    logic [31:0] now, held;
    logic [7:0] c;
    kp = t.key_down; bp = t.boot_down; now = t.now_ms;
    free = 0;
    tick_out.delete();
    if (g_mode == MODE_NORMAL) begin
      if (kp && bp) begin
        g_mode = MODE_COMBO; g_mode_t0 = now;
        g_kflags[FDown] = 0; g_bflags[FDown] = 0; g_tally = 0;
      end else begin
        free = 1;
      end
    end else if (g_mode == MODE_COMBO) begin
      if (!(kp && bp)) begin
        g_mode = MODE_NORMAL; g_kflags[FDown] = 0; g_bflags[FDown] = 0;
      end else if ((now - g_mode_t0) >= {16'd0, cfg.dual_hold_ms}) begin
        arm_action(ACT_DEEP, 1, now);
      end
    end else begin
      armed_step(kp, bp, now);
    end
    if (free) begin
      // KEY side
      if (kp && !g_kflags[FDown]) begin
        g_key_t0 = now;
        g_kflags = {!g_screen, 1'b0, 1'b1};
        if (!g_screen) begin
          g_screen = 1; post(EV_WAKE, 0, 0, ACT_NONE);
        end
        g_touch_t = now;
      end else if (kp && g_kflags[FDown] && !g_kflags[FLong] && !g_kflags[FWake] &&
                   (now - g_key_t0) >= {16'd0, cfg.reboot_hold_ms}) begin
        g_kflags[FLong] = 1; g_tally = 0;
        arm_action(ACT_REBOOT, 1, now);
      end else if (!kp && g_kflags[FDown]) begin
        held = now - g_key_t0;
        g_kflags[FDown] = 0;
        if (!g_kflags[FLong] && !g_kflags[FWake] && held >= ShortMinMs) begin
          if (g_tally != 8'd255) g_tally++;
          g_click_t = now;
        end
      end
      // BOOT side
      if (bp && !g_bflags[FDown]) begin
        g_boot_t0 = now;
        g_bflags = {!g_screen, 1'b0, 1'b1};
        if (!g_screen) begin
          g_screen = 1; post(EV_WAKE, 0, 0, ACT_NONE);
        end
        g_touch_t = now;
      end else if (bp && g_bflags[FDown] && !g_bflags[FLong] && !g_bflags[FWake] &&
                   (now - g_boot_t0) >= {16'd0, cfg.screen_off_hold_ms}) begin
        g_bflags[FLong] = 1;
        arm_action(ACT_OFF, 1, now);
      end else if (!bp && g_bflags[FDown]) begin
        held = now - g_boot_t0;
        g_bflags[FDown] = 0;
        if (!g_bflags[FLong] && !g_bflags[FWake] && held >= ShortMinMs)
          post(EV_ROTATE, 0, 0, ACT_NONE);
      end
      // close a burst once the window has passed
      if (g_tally != 0 && (now - g_click_t) > {16'd0, cfg.burst_window_ms}) begin
        c = g_tally;
        g_tally = 0;
        if (c == 8'd2) post(EV_TOGGLE, 0, 0, ACT_NONE);
        else post(EV_STEP, c, 0, ACT_NONE);
      end
      // idle arming with a dark screen
      if (!g_screen && cfg.idle_sleep_min != 0 &&
          (now - g_touch_t) >= {24'd0, cfg.idle_sleep_min} * 32'd60000)
        arm_action(ACT_LIGHT, 0, now);
    end
    if (tick_out.size() > 0) tick_out[tick_out.size()-1].last_of_tick = 1'b1;
    foreach (tick_out[i]) expected_results.push_back(tick_out[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // valid stays high into the next beat when no gap is drawn
  task automatic send_tick(logic kp, logic bp, logic [31:0] now);
    int gap;
    tick_t t;
    gap = $urandom_range(0, 15);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      tick_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    t.key_down = kp; t.boot_down = bp; t.now_ms = now;
    tick <= t;
    tick_valid <= 1'b1;
    do @(posedge clk); while (!tick_ready);
    predict_gestures(t);
  endtask

  // advance the clock by dt and send the levels
  task automatic press(logic kp, logic bp, int unsigned dt);
    now_clock = now_clock + dt;
    send_tick(kp, bp, now_clock);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= AddrW'({idx, 2'b00}); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_BURST:   cfg.burst_window_ms = val[15:0];
      REG_OFFHOLD: cfg.screen_off_hold_ms = val[15:0];
      REG_RBHOLD:  cfg.reboot_hold_ms = val[15:0];
      REG_COMBO:   cfg.dual_hold_ms = val[15:0];
      REG_FACTORY: cfg.factory_hold_ms = val[15:0];
      REG_ARMS:    cfg.countdown_short_ms = val[15:0];
      REG_ARML:    cfg.countdown_long_ms = val[15:0];
      REG_IDLE:    cfg.idle_sleep_min = val[7:0];
      default: ;
    endcase
  endtask

  // drop valid, wait for every expected beat, then a few spare cycles
  task automatic drain();
    tick_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result receiver and checker
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected beat %h", $realtime, result);
          failures++;
        end else begin
          automatic result_t e = expected_results.pop_front();
          if (e.event_res != result.event_res || e.click_count != result.click_count ||
              e.countdown_secs != result.countdown_secs ||
              e.armed_action != result.armed_action ||
              e.screen_is_on != result.screen_is_on ||
              e.last_of_tick != result.last_of_tick) begin
            $display("%0t: mismatch expected %h actual %h", $realtime, e, result);
            failures++;
          end
        end
      end
      // hold ready low for a drawn number of cycles per beat, or during a hold-off
      if (hold_off) begin
        result_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        result_ready <= 1'b0;
      end else if (result_valid && result_ready) begin
        stall_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if ((tick_valid && tick_ready) || (result_valid && result_ready) || rst || hold_off)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_clicks();
    press(1, 0, 10); press(0, 0, 60);             // one click
    press(0, 0, 300);                              // burst closes: step 1
    press(1, 0, 10); press(0, 0, 60);
    press(1, 0, 20); press(0, 0, 60); press(0, 0, 400); // toggle
    press(1, 0, 10); press(0, 0, 20); press(0, 0, 400); // too short
    press(0, 1, 10); press(0, 0, 80);              // rotate
  endtask

  task automatic test_boot_off_and_wake();
    press(0, 1, 10); press(0, 1, 2500);            // arm screen off
    press(0, 1, 100); press(0, 0, 100);            // countdown then released
    press(0, 0, 1000); press(0, 0, 3000);          // expiry: screen off
    press(1, 0, 100); press(0, 0, 100);            // wake
  endtask

  task automatic test_reboot_cancel_factory();
    press(1, 0, 10); press(1, 0, 10001);           // arm reboot
    press(0, 0, 100); press(1, 0, 500);            // cancel by KEY
    press(0, 0, 100);
    press(1, 0, 10); press(1, 0, 10001); press(0, 0, 100);
    press(0, 1, 100); press(0, 1, 1100); press(0, 1, 1000); // factory
    press(1, 1, 10); press(1, 1, 5001); press(1, 1, 100);   // combo -> deep armed
    press(0, 0, 100); press(0, 0, 6000);                     // deep fires
  endtask

  task automatic test_extremes();
    write_reg(REG_BURST, 32'd0); write_reg(REG_OFFHOLD, 32'd0);
    write_reg(REG_RBHOLD, 32'd65535); write_reg(REG_COMBO, 32'd0);
    write_reg(REG_FACTORY, 32'd0); write_reg(REG_ARMS, 32'd65535);
    write_reg(REG_ARML, 32'd0); write_reg(REG_IDLE, 32'd1);
    press(0, 1, 5); press(0, 1, 1); press(0, 0, 1);  // zero hold arms off
    press(0, 0, 70000); press(0, 0, 70000);          // dark, then idle sleep
    press(0, 0, 10); press(0, 0, 70000);
    press(1, 1, 1); press(1, 1, 1); press(0, 0, 1); press(0, 0, 1);
    now_clock = 32'hFFFF_FF00;                        // wrap of the time base
    press(1, 0, 10); press(0, 0, 300); press(0, 0, 300);
    drain();
    write_reg(REG_IDLE, 32'd255); write_reg(REG_ARMS, 32'd3000);
    write_reg(REG_RBHOLD, 32'd0); write_reg(REG_FACTORY, 32'd65535);
    write_reg(REG_ARML, 32'd65535); write_reg(REG_BURST, 32'd65535);
    write_reg(REG_OFFHOLD, 32'd65535); write_reg(REG_COMBO, 32'd65535);
    press(1, 0, 10); press(1, 0, 1); press(0, 0, 5); press(0, 1, 5); press(0, 1, 70000);
    press(1, 0, 10); press(0, 0, 10);
    drain();
  endtask

  // random press sequences with millisecond-scale timing, medium thresholds
  task automatic test_random_sequences(int n);
    int k, dt;
    logic kp, bp;
    write_reg(REG_BURST, 32'd200); write_reg(REG_OFFHOLD, 32'd800);
    write_reg(REG_RBHOLD, 32'd1500); write_reg(REG_COMBO, 32'd900);
    write_reg(REG_FACTORY, 32'd700); write_reg(REG_ARMS, 32'd1200);
    write_reg(REG_ARML, 32'd2500); write_reg(REG_IDLE, 32'd1);
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 4))
        0: begin
          kp = 1'($urandom_range(0, 1)); bp = 0;
        end
        1: begin
          kp = 0; bp = 1'($urandom_range(0, 1));
        end
        2: begin
          kp = 1; bp = 1;
        end
        default: begin
          kp = 1'($urandom_range(0, 1)); bp = 1'($urandom_range(0, 1));
        end
      endcase
      case ($urandom_range(0, 9))
        0: dt = $urandom_range(0, 3);
        1: dt = 60000 + $urandom_range(0, 20000);
        2: dt = $urandom_range(500, 3000);
        default: dt = $urandom_range(20, 400);
      endcase
      if (k == n / 2) begin
        now_clock = $urandom;   // random time base keeps all bits moving
      end
      press(kp, bp, dt);
    end
  endtask

  // hold the receiver off while BOOT taps keep producing rotates, so the queue fills
  task automatic test_backpressure();
    int k;
    hold_off = 1'b1;
    fork
      begin
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (k = 0; k < 20; k++) press(1'b0, k[1], 30);
      end
    join
  endtask

  initial begin
    cfg = '{burst_window_ms: 16'd280, screen_off_hold_ms: 16'd2000,
            reboot_hold_ms: 16'd10000, dual_hold_ms: 16'd5000,
            factory_hold_ms: 16'd2000, countdown_short_ms: 16'd3000,
            countdown_long_ms: 16'd5000, idle_sleep_min: 8'd0};
    clear_gestures();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_clicks();
    test_boot_off_and_wake();
    test_reboot_cancel_factory();
    drain();
    test_extremes();
    test_random_sequences(80);
    test_backpressure();
    drain();
    repeat (20) @(posedge clk);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
sv/gtc_pkg.sv
sv/gtc_front.sv
sv/gtc_queue.sv
sv/gtc_back.sv
sv/two_button_gesture_controller.sv
tb/testbench.sv
